[sv/emp_pkg.sv]
// ----------------------------------------------------------------------------
// emp_pkg: shared types, codes and tables for the ego-motion point transform
// Holds the configuration bundle, the queued item, the sequencer states,
// the CORDIC arctangent table and the rounding/saturation helper.
// ----------------------------------------------------------------------------
package emp_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CordicSteps   = 16;
    localparam int StepWidth     = $clog2(CordicSteps);
    localparam int TrigWidth     = 18;
    localparam int CoordWidth    = 32;
    localparam int DiffWidth     = CoordWidth + 1;
    localparam int ProdWidth     = TrigWidth + DiffWidth;
    localparam int SumWidth      = ProdWidth + 1;

    localparam logic [CfgIndexWidth-1:0] REG_PREV_POS_X   = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_PREV_POS_Y   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_PREV_HEADING = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_CUR_POS_X    = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_CUR_POS_Y    = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_CUR_HEADING  = 3'd5;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [TrigWidth-1:0] TRIG_ONE = 18'sd65536;

    typedef struct packed {
        logic signed [CoordWidth-1:0] prev_pos_x;
        logic signed [CoordWidth-1:0] prev_pos_y;
        logic [15:0]                  prev_heading;
        logic signed [CoordWidth-1:0] cur_pos_x;
        logic signed [CoordWidth-1:0] cur_pos_y;
        logic [15:0]                  cur_heading;
    } cfg_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] point_x;
        logic signed [CoordWidth-1:0] point_y;
        logic                         frame_start;
        logic                         last_in;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG_PREV,
        ST_OFS_MUL,
        ST_OFS_SUM,
        ST_TRIG_DIFF,
        ST_PT_MUL,
        ST_PT_SUM
    } back_state_t;

    // arctangent of 2^-i in units of 1/65536 turn
    function automatic logic signed [17:0] atan_turn(input logic [StepWidth-1:0] i);
        logic signed [17:0] v;
        unique case (i)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            4'd14:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    // round half up to Q16 and clamp to the signed 32-bit range
    function automatic logic signed [CoordWidth-1:0] round_sat(
        input logic signed [SumWidth-1:0] v
    );
        logic signed [SumWidth-1:0] r;
        logic signed [CoordWidth-1:0] res;
        r = (v + 52'sd32768) >>> 16;
        if (r > 52'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (r < -52'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = r[CoordWidth-1:0];
        end
        return res;
    endfunction

endpackage

[sv/emp_queue.sv]
// ----------------------------------------------------------------------------
// emp_queue: front end input queue
// Accepts input beats and holds up to two items for the back end sequencer.
// ----------------------------------------------------------------------------
module emp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  emp_pkg::item_t push_item,
    output logic          full,
    output logic          q_valid,
    output emp_pkg::item_t q_item,
    input  logic          pop
);
    import emp_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/emp_cordic.sv]
// ----------------------------------------------------------------------------
// emp_cordic: iterative sine/cosine unit
// Quarter-turn reduction, then one CORDIC rotation step per cycle;
// results rounded to Q16 and mapped back to the quadrant.
// ----------------------------------------------------------------------------
module emp_cordic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [15:0]                         angle,
    output logic                                done,
    output logic signed [emp_pkg::TrigWidth-1:0] cos_out,
    output logic signed [emp_pkg::TrigWidth-1:0] sin_out
);
    import emp_pkg::*;

    logic signed [33:0]          x_reg, x_next;
    logic signed [33:0]          y_reg, y_next;
    logic signed [17:0]          r_reg, r_next;
    logic [1:0]                  q_reg, q_next;
    logic [StepWidth-1:0]        step_reg, step_next;
    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [15:0]                 biased;
    logic [15:0]                 residual;
    logic signed [33:0]          x_rnd, y_rnd;
    logic signed [TrigWidth-1:0] cc, ss;

    assign biased   = angle + 16'd8192;
    assign residual = angle - {biased[15:14], 14'd0};

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = CORDIC_GAIN_Q30;
            y_next    = 34'sd0;
            r_next    = 18'(signed'(residual));
            q_next    = biased[15:14];
            step_next = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            if (r_reg >= 18'sd0) begin
                x_next = x_reg - (y_reg >>> step_reg);
                y_next = y_reg + (x_reg >>> step_reg);
                r_next = r_reg - atan_turn(step_reg);
            end else begin
                x_next = x_reg + (y_reg >>> step_reg);
                y_next = y_reg - (x_reg >>> step_reg);
                r_next = r_reg + atan_turn(step_reg);
            end
            step_next = step_reg + StepWidth'(1);
            if (step_reg == StepWidth'(CordicSteps - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign x_rnd = (x_reg + 34'sd8192) >>> 14;
    assign y_rnd = (y_reg + 34'sd8192) >>> 14;
    assign cc    = x_rnd[TrigWidth-1:0];
    assign ss    = y_rnd[TrigWidth-1:0];
    assign done  = done_reg;

    always_comb begin
        case (q_reg)
            2'd0: begin
                cos_out = cc;
                sin_out = ss;
            end
            2'd1: begin
                cos_out = -ss;
                sin_out = cc;
            end
            2'd2: begin
                cos_out = -cc;
                sin_out = -ss;
            end
            default: begin
                cos_out = ss;
                sin_out = -cc;
            end
        endcase
    end

endmodule

[sv/emp_back.sv]
// ----------------------------------------------------------------------------
// emp_back: back end sequencer and rotation datapath
// Derives the frame terms on a frame start, then rotates each point through
// four registered multipliers and a rounding, saturating sum stage.
// ----------------------------------------------------------------------------
module emp_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  emp_pkg::cfg_t                        cfg,
    input  logic                                 q_valid,
    input  emp_pkg::item_t                       q_item,
    output logic                                 q_pop,
    output logic                                 out_valid,
    output logic signed [emp_pkg::CoordWidth-1:0] out_x,
    output logic signed [emp_pkg::CoordWidth-1:0] out_y,
    output logic                                 out_last,
    input  logic                                 out_ready
);
    import emp_pkg::*;

    back_state_t state_reg, state_next;

    logic signed [CoordWidth-1:0] offset_x_reg, offset_x_next;
    logic signed [CoordWidth-1:0] offset_y_reg, offset_y_next;
    logic signed [TrigWidth-1:0]  rot_cos_reg, rot_cos_next;
    logic signed [TrigWidth-1:0]  rot_sin_reg, rot_sin_next;
    logic signed [TrigWidth-1:0]  trig_c_reg, trig_c_next;
    logic signed [TrigWidth-1:0]  trig_s_reg, trig_s_next;
    logic signed [CoordWidth-1:0] pt_x_reg, pt_y_reg;
    logic                         pt_last_reg;
    logic signed [ProdWidth-1:0]  p_cx_reg, p_sy_reg, p_sx_reg, p_cy_reg;
    logic                         out_valid_reg, out_valid_next;
    logic signed [CoordWidth-1:0] out_x_reg, out_x_next;
    logic signed [CoordWidth-1:0] out_y_reg, out_y_next;
    logic                         out_last_reg, out_last_next;

    logic                         cordic_start;
    logic [15:0]                  cordic_angle;
    logic                         cordic_done;
    logic signed [TrigWidth-1:0]  cordic_cos, cordic_sin;

    logic signed [TrigWidth-1:0]  coef_c, coef_s;
    logic signed [DiffWidth-1:0]  arg_x, arg_y;
    logic signed [ProdWidth-1:0]  p_cx, p_sy, p_sx, p_cy;
    logic signed [CoordWidth-1:0] rot_x, rot_y;
    logic                         out_free;

    emp_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .cos_out (cordic_cos),
        .sin_out (cordic_sin)
    );

    assign out_free = !out_valid_reg || out_ready;

    // shared rotation: offsets use the previous-heading trig, points the
    // stored heading-change trig
    always_comb begin
        if (state_reg == ST_PT_MUL) begin
            coef_c = rot_cos_reg;
            coef_s = rot_sin_reg;
            arg_x  = DiffWidth'(pt_x_reg) - DiffWidth'(offset_x_reg);
            arg_y  = DiffWidth'(pt_y_reg) - DiffWidth'(offset_y_reg);
        end else begin
            coef_c = trig_c_reg;
            coef_s = trig_s_reg;
            arg_x  = DiffWidth'(cfg.cur_pos_x) - DiffWidth'(cfg.prev_pos_x);
            arg_y  = DiffWidth'(cfg.cur_pos_y) - DiffWidth'(cfg.prev_pos_y);
        end
    end

    assign p_cx  = ProdWidth'(coef_c) * ProdWidth'(arg_x);
    assign p_sy  = ProdWidth'(coef_s) * ProdWidth'(arg_y);
    assign p_sx  = ProdWidth'(coef_s) * ProdWidth'(arg_x);
    assign p_cy  = ProdWidth'(coef_c) * ProdWidth'(arg_y);
    assign rot_x = round_sat(SumWidth'(p_cx_reg) + SumWidth'(p_sy_reg));
    assign rot_y = round_sat(SumWidth'(p_cy_reg) - SumWidth'(p_sx_reg));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = q_item.frame_start ? ST_TRIG_PREV : ST_PT_MUL;
                end
            end
            ST_TRIG_PREV: begin
                if (cordic_done) begin
                    state_next = ST_OFS_MUL;
                end
            end
            ST_OFS_MUL:   state_next = ST_OFS_SUM;
            ST_OFS_SUM:   state_next = ST_TRIG_DIFF;
            ST_TRIG_DIFF: begin
                if (cordic_done) begin
                    state_next = ST_PT_MUL;
                end
            end
            ST_PT_MUL:    state_next = ST_PT_SUM;
            ST_PT_SUM: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop          = 1'b0;
        cordic_start   = 1'b0;
        cordic_angle   = cfg.prev_heading;
        offset_x_next  = offset_x_reg;
        offset_y_next  = offset_y_reg;
        rot_cos_next   = rot_cos_reg;
        rot_sin_next   = rot_sin_reg;
        trig_c_next    = trig_c_reg;
        trig_s_next    = trig_s_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                q_pop        = q_valid;
                cordic_start = q_valid && q_item.frame_start;
            end
            ST_TRIG_PREV: begin
                if (cordic_done) begin
                    trig_c_next = cordic_cos;
                    trig_s_next = cordic_sin;
                end
            end
            ST_OFS_SUM: begin
                offset_x_next = rot_x;
                offset_y_next = rot_y;
                cordic_start  = 1'b1;
                cordic_angle  = cfg.cur_heading - cfg.prev_heading;
            end
            ST_TRIG_DIFF: begin
                if (cordic_done) begin
                    rot_cos_next = cordic_cos;
                    rot_sin_next = cordic_sin;
                end
            end
            ST_PT_SUM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_x_next     = rot_x;
                    out_y_next     = rot_y;
                    out_last_next  = pt_last_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            rot_cos_reg   <= TRIG_ONE;
            rot_sin_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            offset_x_reg  <= offset_x_next;
            offset_y_reg  <= offset_y_next;
            rot_cos_reg   <= rot_cos_next;
            rot_sin_reg   <= rot_sin_next;
        end
    end

    always_ff @(posedge aclk) begin
        trig_c_reg   <= trig_c_next;
        trig_s_reg   <= trig_s_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
        // hold the products while the sum stage waits on the output
        if (state_reg == ST_OFS_MUL || state_reg == ST_PT_MUL) begin
            p_cx_reg <= p_cx;
            p_sy_reg <= p_sy;
            p_sx_reg <= p_sx;
            p_cy_reg <= p_cy;
        end
        if (q_pop) begin
            pt_x_reg    <= q_item.point_x;
            pt_y_reg    <= q_item.point_y;
            pt_last_reg <= q_item.last_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

endmodule

[sv/ego_motion_point_transform.sv]
// Ego-motion point transform. Each input beat carries a 2D point (signed
// Q16.16) and is answered by exactly one output beat with the point moved
// into the current vehicle frame, saturated to 32 bits. A plain point passes
// from the head of the input queue to the output register through pop,
// multiply, and round and sum; the next beat is popped only after the sum
// stage is done, and a full output register holds the point in the sum stage.
// A beat with tuser high first runs the frame setup: two passes of the
// iterative CORDIC plus the offset rotation. A two-entry input queue and the
// output register let both sides stall independently. Write configuration
// only while no beat is in flight.
// ----------------------------------------------------------------------------
// ego_motion_point_transform: planar rigid transform of feature points
// Top level: configuration registers, input queue and back end sequencer.
// ----------------------------------------------------------------------------
module ego_motion_point_transform (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [emp_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,  // point_x, point_y
    input  logic                               s_tuser,  // frame_start
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,  // out_x, out_y
    output logic                               m_tlast
);
    import emp_pkg::*;

    cfg_t  cfg_reg;
    item_t in_item;
    item_t q_item;
    logic  q_full, q_valid, q_pop;
    logic signed [CoordWidth-1:0] res_x, res_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PREV_POS_X:   cfg_reg.prev_pos_x   <= cfg_wdata;
                REG_PREV_POS_Y:   cfg_reg.prev_pos_y   <= cfg_wdata;
                REG_PREV_HEADING: cfg_reg.prev_heading <= cfg_wdata[15:0];
                REG_CUR_POS_X:    cfg_reg.cur_pos_x    <= cfg_wdata;
                REG_CUR_POS_Y:    cfg_reg.cur_pos_y    <= cfg_wdata;
                REG_CUR_HEADING:  cfg_reg.cur_heading  <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.point_x     = s_tdata[31:0];
    assign in_item.point_y     = s_tdata[63:32];
    assign in_item.frame_start = s_tuser;
    assign in_item.last_in     = s_tlast;
    assign s_tready            = !q_full;

    emp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && !q_full),
        .push_item (in_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    emp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_x     (res_x),
        .out_y     (res_y),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    assign m_tdata = {res_y, res_x};

endmodule
